### sv/wildcard_byte_pattern_scan_core_assert.svh
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan core: assertion macros
// Shared concurrent check templates, clocked on i_clk, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_CORE_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_CORE_ASSERT_SVH

// Same-cycle implication check
`define WBPS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check
`define WBPS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/wbps_pkg.sv
// ---------------------------------------------------------------------------
// wbps_pkg
// Types and fixed constants of the wildcard byte pattern scan core.
// ---------------------------------------------------------------------------
package wbps_pkg;

    localparam int PAT_BYTES  = 32;
    localparam int PAT_REGS   = 4;
    localparam int LEN_W      = 6;
    localparam int OFS_W      = 5;
    localparam int ADDR_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WILD_W     = 32;
    localparam int CNT_W      = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;
    localparam logic [CNT_W-1:0] MAX_RESET = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT0 = 3'd0,
        CFG_PAT1 = 3'd1,
        CFG_PAT2 = 3'd2,
        CFG_PAT3 = 3'd3,
        CFG_WILD = 3'd4,
        CFG_LEN  = 3'd5,
        CFG_MAX  = 3'd6
    } t_cfg_reg;

    // One reported hit: address of the newest byte and the window offset
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [OFS_W-1:0]  ofs;
    } t_hit;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

### sv/wbps_front.sv
// ---------------------------------------------------------------------------
// wbps_front
// Accepts bytes, keeps the block window, address and match count, and
// classifies each byte as a reportable hit against the masked pattern.
// ---------------------------------------------------------------------------
module wbps_front #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_in_block,
    input  logic                             i_last_in_block,
    input  logic [wbps_pkg::ADDR_W-1:0]      i_base_address,
    input  wbps_pkg::t_q_status              i_qstat,
    output logic                             o_push,
    output wbps_pkg::t_hit                   o_hit
);

    localparam int LIM = (MAX_PATTERN < wbps_pkg::PAT_BYTES) ? MAX_PATTERN
                                                              : wbps_pkg::PAT_BYTES;
    localparam int WIN = (LIM > 1) ? LIM - 1 : 1;
    localparam int FW  = $clog2(LIM + 1);
    localparam int LW  = wbps_pkg::LEN_W;

    // Configuration registers
    logic [wbps_pkg::CFG_DATA_W-1:0] r_pat [wbps_pkg::PAT_REGS];
    logic [wbps_pkg::CFG_DATA_W-1:0] n_pat [wbps_pkg::PAT_REGS];
    logic [wbps_pkg::WILD_W-1:0]     r_wild, n_wild;
    logic [LW-1:0]                   r_len_raw, n_len_raw;
    logic [wbps_pkg::CNT_W-1:0]      r_max, n_max;

    // Pattern aligned to the window, rebuilt from the next config values
    logic [7:0]    r_apat [LIM];
    logic [7:0]    n_apat [LIM];
    logic [LIM-1:0] r_care, n_care;
    logic [LW-1:0] r_len_act, n_len_act;

    // Scan state
    logic [7:0]                 r_win [WIN];
    logic [FW-1:0]              r_fill, n_fill;
    logic [wbps_pkg::ADDR_W-1:0] r_next, n_next;
    logic [wbps_pkg::CNT_W-1:0] r_count, n_count;

    logic [wbps_pkg::PAT_BYTES*8-1:0] w_pat_flat;
    logic [7:0]                 w_wnew [LIM];
    logic [LIM-1:0]             w_ok;
    logic [FW-1:0]              w_fill_base, w_fill_new;
    logic [wbps_pkg::ADDR_W-1:0] w_addr;
    logic [LW-1:0]              w_len_m1;
    logic                       w_accept, w_hit, w_report;

    // Apply config writes; force reset values while in reset
    always_comb begin
        for (int i = 0; i < wbps_pkg::PAT_REGS; i++) begin
            n_pat[i] = r_pat[i];
        end
        n_wild    = r_wild;
        n_len_raw = r_len_raw;
        n_max     = r_max;
        if (!i_rst_n) begin
            for (int i = 0; i < wbps_pkg::PAT_REGS; i++) begin
                n_pat[i] = '0;
            end
            n_wild    = '0;
            n_len_raw = wbps_pkg::LEN_RESET;
            n_max     = wbps_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            case (wbps_pkg::t_cfg_reg'(i_cfg_index))
                wbps_pkg::CFG_PAT0, wbps_pkg::CFG_PAT1,
                wbps_pkg::CFG_PAT2, wbps_pkg::CFG_PAT3: begin
                    n_pat[i_cfg_index[1:0]] = i_cfg_data;
                end
                wbps_pkg::CFG_WILD: n_wild    = i_cfg_data[wbps_pkg::WILD_W-1:0];
                wbps_pkg::CFG_LEN:  n_len_raw = i_cfg_data[LW-1:0];
                wbps_pkg::CFG_MAX:  n_max     = i_cfg_data[wbps_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp length and align pattern bytes to window slots (slot 0 = newest)
    always_comb begin
        logic [LW-1:0] idx;
        logic [LW-1:0] len_m1;
        for (int i = 0; i < wbps_pkg::PAT_REGS; i++) begin
            w_pat_flat[i*wbps_pkg::CFG_DATA_W +: wbps_pkg::CFG_DATA_W] = n_pat[i];
        end
        if (n_len_raw == '0) begin
            n_len_act = LW'(1);
        end else if (n_len_raw > LW'(LIM)) begin
            n_len_act = LW'(LIM);
        end else begin
            n_len_act = n_len_raw;
        end
        len_m1 = n_len_act - LW'(1);
        idx    = '0;
        for (int j = 0; j < LIM; j++) begin
            idx       = len_m1 - LW'(j);
            n_apat[j] = w_pat_flat[{idx[wbps_pkg::OFS_W-1:0], 3'b000} +: 8];
            n_care[j] = (LW'(j) < n_len_act) && !n_wild[idx[wbps_pkg::OFS_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < wbps_pkg::PAT_REGS; i++) begin
            r_pat[i] <= n_pat[i];
        end
        r_wild    <= n_wild;
        r_len_raw <= n_len_raw;
        r_max     <= n_max;
        r_apat    <= n_apat;
        r_care    <= n_care;
        r_len_act <= n_len_act;
    end

    // Classify the incoming byte against the shifted window
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_fill_base = i_first_in_block ? '0 : r_fill;
    assign w_fill_new  = (w_fill_base == FW'(LIM)) ? w_fill_base : w_fill_base + FW'(1);
    assign w_addr      = i_first_in_block ? i_base_address : r_next;
    assign w_len_m1    = r_len_act - LW'(1);

    always_comb begin
        w_wnew[0] = i_data_byte;
        for (int j = 1; j < LIM; j++) begin
            w_wnew[j] = r_win[j-1];
        end
        for (int j = 0; j < LIM; j++) begin
            w_ok[j] = !r_care[j] || (w_wnew[j] == r_apat[j]);
        end
    end

    assign w_hit    = ((LW+1)'(w_fill_new) >= (LW+1)'(r_len_act)) && (&w_ok);
    assign w_report = w_hit && (r_count < r_max);

    // Next scan state
    always_comb begin
        n_fill  = r_fill;
        n_next  = r_next;
        n_count = r_count;
        if (w_accept) begin
            n_fill = i_last_in_block ? '0 : w_fill_new;
            n_next = w_addr + wbps_pkg::ADDR_W'(1);
            if (w_report) begin
                n_count = r_count + wbps_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_next  <= '0;
            r_count <= '0;
        end else begin
            r_fill  <= n_fill;
            r_next  <= n_next;
            r_count <= n_count;
        end
    end

    // Shift the window on every accepted byte
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[0] <= i_data_byte;
            for (int j = 1; j < WIN; j++) begin
                r_win[j] <= r_win[j-1];
            end
        end
    end

    assign o_in_ready = !i_qstat.full;
    assign o_push     = w_accept && w_report;
    assign o_hit.addr = w_addr;
    assign o_hit.ofs  = w_len_m1[wbps_pkg::OFS_W-1:0];

endmodule

### sv/wbps_queue.sv
// ---------------------------------------------------------------------------
// wbps_queue
// Short FIFO of classified hits between the front and back parts.
// ---------------------------------------------------------------------------
module wbps_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wbps_pkg::t_hit      i_data,
    input  logic                i_pop,
    output wbps_pkg::t_hit      o_data,
    output wbps_pkg::t_q_status o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wbps_pkg::t_hit r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;

    // Advance pointers and occupancy
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.valid = (r_cnt != '0);

endmodule

### sv/wbps_back.sv
// ---------------------------------------------------------------------------
// wbps_back
// Drains the hit queue, forms the window start address and holds it in
// the output register until taken.
// ---------------------------------------------------------------------------
module wbps_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wbps_pkg::t_q_status         i_qstat,
    input  wbps_pkg::t_hit              i_hit,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [wbps_pkg::ADDR_W-1:0] o_match_address
);

    logic                        r_valid;
    logic [wbps_pkg::ADDR_W-1:0] r_addr;

    // Pop when the output register is free or being emptied
    assign o_pop = i_qstat.valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Step back from the newest byte to the first byte of the window
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= i_hit.addr - wbps_pkg::ADDR_W'(i_hit.ofs);
        end
    end

    assign o_out_valid     = r_valid;
    assign o_match_address = r_addr;

endmodule

### sv/wildcard_byte_pattern_scan_core.sv
// A matching byte, once accepted, is pushed into the hit queue; its start address
// is then registered onto o_match_address when the output register can take it.
// Throughput: one byte per cycle; the front stalls only when the hit queue
// (QUEUE_DEPTH entries) is full because the output side is held.
// Reset (i_rst_n low, synchronous): config returns to pattern 0, no wildcards,
// length 1, limit 65535; window fill, address and match count clear.
// ---------------------------------------------------------------------------
// wildcard_byte_pattern_scan_core
// Scans a stream of block bytes for a wildcard byte pattern and reports the
// start address of every match, up to a configured match limit.
// ---------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_core_assert.svh"

module wildcard_byte_pattern_scan_core #(
    parameter int MAX_PATTERN = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_first_in_block,
    input  logic                             i_last_in_block,
    input  logic [wbps_pkg::ADDR_W-1:0]      i_base_address,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [wbps_pkg::ADDR_W-1:0]      o_match_address
);

    logic                w_push, w_pop;
    wbps_pkg::t_hit      w_hit_in, w_hit_out;
    wbps_pkg::t_q_status w_qstat;

    // Front: accept and classify bytes
    wbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_first_in_block (i_first_in_block),
        .i_last_in_block  (i_last_in_block),
        .i_base_address   (i_base_address),
        .i_qstat          (w_qstat),
        .o_push           (w_push),
        .o_hit            (w_hit_in)
    );

    // Queue: decouple classification from delivery
    wbps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_hit_in),
        .i_pop   (w_pop),
        .o_data  (w_hit_out),
        .o_stat  (w_qstat)
    );

    // Back: form and deliver match addresses
    wbps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_qstat         (w_qstat),
        .i_hit           (w_hit_out),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_match_address (o_match_address)
    );

    // Checks
    `WBPS_CHECK_NOW(a_no_push_full, w_push, !w_qstat.full, "hit pushed into full queue")
    `WBPS_CHECK_NOW(a_no_pop_empty, w_pop, w_qstat.valid, "pop from empty queue")
    `WBPS_CHECK_NEXT(a_empty_stays, !w_qstat.valid && !w_push, !w_qstat.valid,
                     "queue filled without a push")
    `WBPS_CHECK_NEXT(a_full_stays, w_qstat.full && !w_pop, w_qstat.full,
                     "queue drained without a pop")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Wildcard byte pattern scan core testbench
// Drives block byte requests through the scan core and predicts every match
// address from its own model of the window, pattern, wildcards and match
// limit. Each reported address is compared with the oldest prediction. Both
// handshake sides stall at random, and the pattern setup changes between
// phases while the core is idle.
// ---------------------------------------------------------------------------
module testbench;

    localparam int SETTLE_CYCLES = 4;
    localparam int RECONFIG_BYTES = 60;
    localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [7:0]                      data_byte = '0;
    logic                            first_in_block = 1'b0;
    logic                            last_in_block = 1'b0;
    logic [wbps_pkg::ADDR_W-1:0]     base_address = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [wbps_pkg::ADDR_W-1:0]     match_address;

    // Scanner model state and its copy of the setup registers
    logic [7:0]                  scan_window [wbps_pkg::PAT_BYTES];
    int                          scan_fill;
    logic [wbps_pkg::ADDR_W-1:0] scan_next_addr;
    logic [wbps_pkg::CNT_W-1:0]  hit_count;
    logic [63:0]                 pat_regs [wbps_pkg::PAT_REGS];
    logic [wbps_pkg::WILD_W-1:0] wild_mask;
    logic [wbps_pkg::LEN_W-1:0]  len_code;
    logic [wbps_pkg::CNT_W-1:0]  hit_limit;

    logic [wbps_pkg::ADDR_W-1:0] expected_match_addrs [$];
    logic [wbps_pkg::ADDR_W-1:0] want_addr;
    int                          errors = 0;
    int                          send_idle_pct = 24;
    int                          recv_idle_pct = 57;

    wildcard_byte_pattern_scan_core i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_data_byte      (data_byte),
        .i_first_in_block (first_in_block),
        .i_last_in_block  (last_in_block),
        .i_base_address   (base_address),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_match_address  (match_address)
    );

    // Free-running 100 MHz clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the core hangs
    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stall the result side at random
    initial begin
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each accepted match address with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_match_addrs.size() == 0) begin
                $display("%0t: match_address expected none, got %h", $time, match_address);
                errors++;
            end else begin
                want_addr = expected_match_addrs.pop_front();
                if (match_address !== want_addr) begin
                    $display("%0t: match_address expected %h, got %h",
                             $time, want_addr, match_address);
                    errors++;
                end
            end
        end
    end

    function automatic int active_len();
        if (len_code == 0) return 1;
        if (len_code > wbps_pkg::PAT_BYTES) return wbps_pkg::PAT_BYTES;
        return int'(len_code);
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        return pat_regs[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < wbps_pkg::PAT_BYTES; i++) scan_window[i] = 8'h00;
        scan_fill = 0;
    endfunction

    function automatic void reset_scanner();
        for (int i = 0; i < wbps_pkg::PAT_REGS; i++) pat_regs[i] = '0;
        wild_mask = '0;
        len_code = wbps_pkg::LEN_RESET;
        hit_limit = wbps_pkg::MAX_RESET;
        scan_next_addr = '0;
        hit_count = '0;
        clear_window();
    endfunction

    // Advance the scanner by one byte and queue the match address it yields
    function automatic void predict_scan(input logic [7:0] b, input logic first,
                                         input logic last,
                                         input logic [wbps_pkg::ADDR_W-1:0] base);
        int L;
        logic hit;
        logic [wbps_pkg::ADDR_W-1:0] addr;
        L = active_len();
        if (first) begin
            clear_window();
            scan_next_addr = base;
        end
        addr = scan_next_addr;
        scan_next_addr = scan_next_addr + 64'd1;
        for (int i = wbps_pkg::PAT_BYTES - 1; i > 0; i--) scan_window[i] = scan_window[i - 1];
        scan_window[0] = b;
        if (scan_fill < wbps_pkg::PAT_BYTES) scan_fill++;
        if (scan_fill >= L) begin
            hit = 1'b1;
            for (int k = 0; k < L; k++) begin
                if (!wild_mask[k] && scan_window[L - 1 - k] != pattern_byte(k)) hit = 1'b0;
            end
            if (hit && hit_count < hit_limit) begin
                expected_match_addrs = {expected_match_addrs, addr - 64'(L - 1)};
                hit_count++;
            end
        end
        if (last) clear_window();
    endfunction

    // Offer one byte request, idling first at random, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [wbps_pkg::ADDR_W-1:0] base);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        first_in_block <= first;
        last_in_block <= last;
        base_address <= base;
        do @(posedge clk); while (!in_ready);
        predict_scan(b, first, last, base);
    endtask

    // Hold off requests until every predicted match has come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_match_addrs.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wbps_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wbps_pkg::CFG_PAT0: pat_regs[0] = val;
            wbps_pkg::CFG_PAT1: pat_regs[1] = val;
            wbps_pkg::CFG_PAT2: pat_regs[2] = val;
            wbps_pkg::CFG_PAT3: pat_regs[3] = val;
            wbps_pkg::CFG_WILD: wild_mask = val[wbps_pkg::WILD_W-1:0];
            wbps_pkg::CFG_LEN:  len_code = val[wbps_pkg::LEN_W-1:0];
            wbps_pkg::CFG_MAX:  hit_limit = val[wbps_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Reset setup: pattern byte zero of length one, bytes before any block start
    task automatic test_reset_state();
        send_byte(8'h00, 1'b0, 1'b0, '1);
        send_byte(8'hFF, 1'b0, 1'b0, '1);
        wait_idle();
    endtask

    // Address wrap, window clear after last, byte after last, one-byte block
    task automatic test_block_edges();
        write_reg(wbps_pkg::CFG_PAT0, 64'h0000_0000_0000_A55A);
        write_reg(wbps_pkg::CFG_LEN, 64'd2);
        send_byte(8'h5A, 1'b1, 1'b0, '1);
        send_byte(8'hA5, 1'b0, 1'b1, '0);
        send_byte(8'h5A, 1'b0, 1'b1, '0);
        send_byte(8'hA5, 1'b0, 1'b0, '0);
        send_byte(8'h5A, 1'b1, 1'b1, 64'h0000_1234_5678_9ABC);
        wait_idle();
    endtask

    // A zero length behaves as one
    task automatic test_length_codes();
        write_reg(wbps_pkg::CFG_LEN, 64'd0);
        send_byte(8'h5A, 1'b1, 1'b1, 64'h8000_0000_0000_0000);
        send_byte(8'hA5, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
        wait_idle();
    endtask

    // Wildcard in the middle, then every position a wildcard
    task automatic test_wildcards();
        write_reg(wbps_pkg::CFG_PAT0, 64'h0000_0000_0033_2211);
        write_reg(wbps_pkg::CFG_WILD, 64'h0000_0000_8000_0002);
        write_reg(wbps_pkg::CFG_LEN, 64'd3);
        send_byte(8'h11, 1'b1, 1'b0, 64'h0000_0000_0000_1000);
        send_byte(8'h99, 1'b0, 1'b0, '0);
        send_byte(8'h33, 1'b0, 1'b0, '0);
        send_byte(8'h11, 1'b0, 1'b0, '0);
        send_byte(8'h22, 1'b0, 1'b0, '0);
        send_byte(8'h34, 1'b0, 1'b1, '0);
        wait_idle();
        write_reg(wbps_pkg::CFG_WILD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 1'b1, 1'b0, 64'h0000_0000_0000_2000);
        send_byte(8'h80, 1'b0, 1'b0, '0);
        send_byte(8'hFF, 1'b0, 1'b1, '0);
        wait_idle();
    endtask

    // Limit of zero, saturation at the limit, limit lowered below the count
    task automatic test_match_limit();
        write_reg(wbps_pkg::CFG_PAT0, 64'h0000_0000_0000_005A);
        write_reg(wbps_pkg::CFG_WILD, 64'd0);
        write_reg(wbps_pkg::CFG_LEN, 64'd1);
        write_reg(wbps_pkg::CFG_MAX, 64'd0);
        send_byte(8'h5A, 1'b1, 1'b0, 64'h0000_0000_0000_3000);
        send_byte(8'h5A, 1'b0, 1'b0, '0);
        wait_idle();
        write_reg(wbps_pkg::CFG_MAX, 64'(hit_count + 16'd1));
        send_byte(8'h5A, 1'b0, 1'b0, '0);
        send_byte(8'h5A, 1'b0, 1'b1, '0);
        wait_idle();
        write_reg(wbps_pkg::CFG_MAX, 64'(hit_count - 16'd1));
        send_byte(8'h5A, 1'b1, 1'b1, 64'h0000_0000_0000_4000);
        wait_idle();
        // An index past the register list must leave the setup alone
        write_reg(CFG_SPARE, '1);
        write_reg(wbps_pkg::CFG_MAX, 64'(wbps_pkg::MAX_RESET));
    endtask

    // New random setup: lengths mostly short, with the extremes now and then
    task automatic randomize_config();
        logic [63:0] junk;
        logic [31:0] wild;
        logic [5:0]  code;
        logic [15:0] limit;
        junk = {$urandom, $urandom};
        write_reg(wbps_pkg::CFG_PAT0, {$urandom, $urandom});
        write_reg(wbps_pkg::CFG_PAT1, {$urandom, $urandom});
        write_reg(wbps_pkg::CFG_PAT2, {$urandom, $urandom});
        write_reg(wbps_pkg::CFG_PAT3, {$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: wild = '0;
            1: wild = '1;
            default: wild = $urandom & $urandom & $urandom;
        endcase
        write_reg(wbps_pkg::CFG_WILD, {junk[63:32], wild});
        case ($urandom_range(0, 9))
            0: code = 6'd0;
            1: code = 6'd32;
            2: code = 6'($urandom_range(33, 63));
            default: code = 6'($urandom_range(1, 6));
        endcase
        write_reg(wbps_pkg::CFG_LEN, {junk[63:6], code});
        if ($urandom_range(0, 7) == 0) limit = hit_count + 16'($urandom_range(0, 3));
        else limit = wbps_pkg::MAX_RESET;
        write_reg(wbps_pkg::CFG_MAX, {junk[63:16], limit});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, junk);
    endtask

    // Random blocks, most carrying a planted copy of the pattern
    task automatic test_random_scan(input int n_items, input int snd_pct, input int rcv_pct);
        logic [7:0]                  blk [64];
        logic [wbps_pkg::ADDR_W-1:0] base;
        logic                        first_f;
        logic                        last_f;
        int                          sent;
        int                          since_cfg;
        int                          blk_len;
        int                          L;
        int                          ofs;
        int                          mode;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        sent = 0;
        since_cfg = RECONFIG_BYTES;
        while (sent < n_items) begin
            if (since_cfg >= RECONFIG_BYTES) begin
                wait_idle();
                randomize_config();
                since_cfg = 0;
            end
            L = active_len();
            blk_len = $urandom_range(1, L + 10);
            for (int i = 0; i < blk_len; i++) blk[i] = 8'($urandom);
            if (blk_len >= L && $urandom_range(0, 3) != 0) begin
                ofs = $urandom_range(0, blk_len - L);
                for (int k = 0; k < L; k++) begin
                    if (!wild_mask[k]) blk[ofs + k] = pattern_byte(k);
                end
            end
            if ($urandom_range(0, 7) == 0) base = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
            else base = {$urandom, $urandom};
            // Mostly clean blocks; some lack a start or an end, some have stray flags
            mode = $urandom_range(0, 9);
            for (int i = 0; i < blk_len; i++) begin
                first_f = (i == 0) && (mode != 0);
                last_f = (i == blk_len - 1) && (mode != 1);
                if (mode == 2) begin
                    first_f = ($urandom_range(0, 7) == 0);
                    last_f = ($urandom_range(0, 7) == 0);
                end
                send_byte(blk[i], first_f, last_f, base);
            end
            sent += blk_len;
            since_cfg += blk_len;
        end
    endtask

    initial begin
        reset_scanner();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_block_edges();
        test_length_codes();
        test_wildcards();
        test_match_limit();
        test_random_scan(220, 24, 57);
        test_random_scan(220, 57, 24);
        test_random_scan(220, 0, 0);
        wait_idle();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### wildcard_byte_pattern_scan_core.f
+incdir+sv
sv/wbps_pkg.sv
sv/wbps_front.sv
sv/wbps_queue.sv
sv/wbps_back.sv
sv/wildcard_byte_pattern_scan_core.sv
dv/testbench.sv
